// ===== hw/rtl/asco_pkg.sv =====
// asco_pkg: shared constants and types of the chunk-offset patcher.
// Parse phase codes, atom tags, output queue sizing and the result group type.
// No dependencies.
package asco_pkg;

	// Parse phases
	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_VERFLAGS = 3'd1;
	localparam logic [2:0] PH_COUNT    = 3'd2;
	localparam logic [2:0] PH_ENTRY    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD  = 3'd4;

	// Atom tags, big-endian ASCII
	localparam logic [31:0] TAG_TRAK = 32'h7472_616B;
	localparam logic [31:0] TAG_MDIA = 32'h6D64_6961;
	localparam logic [31:0] TAG_MINF = 32'h6D69_6E66;
	localparam logic [31:0] TAG_STBL = 32'h7374_626C;
	localparam logic [31:0] TAG_STCO = 32'h7374_636F;

	localparam int unsigned HDR_BYTES = 8;

	// Result group: up to four bytes caused by one item
	localparam int unsigned GRP_MAX = 4;
	localparam int unsigned GRP_CW  = $clog2(GRP_MAX + 1);

	// Output queue
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = QAW + 1;

	typedef struct packed {
		logic [GRP_CW-1:0]        n;
		logic [GRP_MAX-1:0][7:0]  data;
		logic [GRP_MAX-1:0]       last;
	} grp_t;

endpackage

// ===== hw/rtl/asco_parse.sv =====
// asco_parse: input register, atom parse state and the byte rewrite logic.
// Produces one result group per consumed item. Depends on asco_pkg.
module asco_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              atom_start,
	input  logic [31:0]       offset_add,
	input  logic              room,
	output logic              grp_we,
	output asco_pkg::grp_t    grp
);
	import asco_pkg::*;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic [63:0] hdr_q, hdr_d;
	logic [23:0] part_q, part_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] left_q, left_d;

	logic        accept;
	logic        consume;

	assign consume  = vld_s1 && room;
	assign in_stall = vld_s1 && !room;
	assign accept   = in_valid && !in_stall;
	assign grp_we   = consume;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (consume) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_byte;
			start_s1 <= atom_start;
		end
	end

	always_comb begin
		logic [2:0]  ph;
		logic [2:0]  ix;
		logic [63:0] hs;
		logic [23:0] pt;
		logic [2:0]  ix4;
		logic [31:0] cnt;
		logic [31:0] sum;
		logic [31:0] size;
		logic [31:0] tag;
		ph  = start_s1 ? PH_HEADER : phase_q;
		ix  = start_s1 ? 3'd0 : idx_q;
		hs  = start_s1 ? 64'd0 : hdr_q;
		pt  = start_s1 ? 24'd0 : part_q;
		ix4 = {1'b0, ix[1:0] + 2'd1};
		cnt = {left_q[23:0], byte_s1};
		sum = {pt, byte_s1} + offset_add;
		size = 32'd0;
		tag  = 32'd0;

		phase_d = ph;
		idx_d   = ix;
		hdr_d   = hs;
		part_d  = pt;
		rem_d   = rem_q;
		left_d  = left_q;

		grp.n    = GRP_CW'(1);
		grp.data = '0;
		grp.last = '0;
		grp.data[0] = byte_s1;
		grp.last[0] = 1'b1;

		case (ph)
			PH_HEADER: begin
				hdr_d = {hs[55:0], byte_s1};
				idx_d = ix + 3'd1;
				size  = hdr_d[63:32];
				tag   = hdr_d[31:0];
				if (idx_d == 3'd0) begin
					if (tag inside {TAG_TRAK, TAG_MDIA, TAG_MINF, TAG_STBL}) begin
						hdr_d = '0;
					end else if (tag == TAG_STCO) begin
						phase_d = PH_VERFLAGS;
						left_d  = '0;
					end else if (size > 32'(HDR_BYTES)) begin
						phase_d = PH_PAYLOAD;
						rem_d   = size - 32'(HDR_BYTES);
					end else begin
						hdr_d = '0;
					end
				end
			end
			PH_VERFLAGS: begin
				idx_d = ix4;
				if (ix4 == 3'd0) begin
					phase_d = PH_COUNT;
					left_d  = '0;
				end
			end
			PH_COUNT: begin
				idx_d  = ix4;
				left_d = cnt;
				if (ix4 == 3'd0) begin
					if (cnt == 32'd0) begin
						phase_d = PH_HEADER;
						hdr_d   = '0;
					end else begin
						phase_d = PH_ENTRY;
						part_d  = '0;
					end
				end
			end
			PH_ENTRY: begin
				if (ix < 3'd3) begin
					// collect the upper bytes of the entry, emit nothing yet
					part_d = {pt[15:0], byte_s1};
					idx_d  = ix + 3'd1;
					grp.n  = '0;
				end else begin
					grp.n    = GRP_CW'(GRP_MAX);
					grp.data = {sum[7:0], sum[15:8], sum[23:16], sum[31:24]};
					grp.last = 4'b1000;
					part_d   = '0;
					idx_d    = '0;
					left_d   = left_q - 32'd1;
					if (left_d == 32'd0) begin
						phase_d = PH_HEADER;
						hdr_d   = '0;
					end
				end
			end
			PH_PAYLOAD: begin
				if (rem_q != 32'd0) begin
					rem_d = rem_q - 32'd1;
				end
				if (rem_d == 32'd0) begin
					phase_d = PH_HEADER;
					idx_d   = '0;
					hdr_d   = '0;
				end
			end
			default: begin
				// unknown phase code: restart with this byte as header byte 0
				phase_d = PH_HEADER;
				hdr_d   = {56'd0, byte_s1};
				idx_d   = 3'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			hdr_q   <= '0;
			part_q  <= '0;
			rem_q   <= '0;
			left_q  <= '0;
		end else if (consume) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			hdr_q   <= hdr_d;
			part_q  <= part_d;
			rem_q   <= rem_d;
			left_q  <= left_d;
		end
	end

endmodule

// ===== hw/rtl/asco_outq.sv =====
// asco_outq: output queue that takes a group of up to four bytes per cycle
// and hands out one byte per cycle while out_stall is low. Depends on asco_pkg.
module asco_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              grp_we,
	input  asco_pkg::grp_t    grp,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              last_of_run
);
	import asco_pkg::*;

	logic [QDEPTH-1:0][8:0] mem_q;
	logic [QAW-1:0]         wr_q;
	logic [QAW-1:0]         rd_q;
	logic [QCW-1:0]         cnt_q;
	logic [GRP_CW-1:0]      push_n;
	logic                   pop;

	assign push_n    = grp_we ? grp.n : '0;
	assign pop       = out_valid && !out_stall;
	assign out_valid = cnt_q != '0;
	assign room      = cnt_q <= QCW'(QDEPTH - GRP_MAX);
	assign out_byte    = mem_q[rd_q][8:1];
	assign last_of_run = mem_q[rd_q][0];

	always_ff @(posedge clk) begin
		for (int k = 0; k < GRP_MAX; k++) begin
			if (GRP_CW'(k) < push_n) begin
				mem_q[wr_q + QAW'(k)] <= {grp.data[k], grp.last[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QAW'(push_n);
			rd_q  <= rd_q + QAW'(pop);
			cnt_q <= cnt_q + QCW'(push_n) - QCW'(pop);
		end
	end

endmodule

// ===== hw/rtl/atom_stream_chunk_offset_patcher.sv =====
// Top level of the movie atom chunk-offset patcher.
// Instantiates asco_parse and asco_outq; depends on asco_pkg.
//
// The block takes the body of a movie atom one byte per item and returns it
// rewritten. Atom headers (8-byte size and tag) pass through; trak, mdia,
// minf and stbl are descended into; the version/flags word and entry count of
// an stco atom pass through, and every 32-bit entry after them comes out with
// offset_add added (mod 2^32), as four bytes released when the entry's fourth
// byte arrives; all other payload bytes pass verbatim. A size below 8 counts
// as an empty payload. Raise atom_start with the first header byte to restart
// parsing. Rate: one item per cycle; an item passes the input register and
// then the output queue. The sole limit is the 8-byte output queue, which takes
// a four-byte burst in one cycle and drains one byte per cycle: with the
// output taken every cycle the input stalls only while more than four bytes
// are queued. Write offset_add only while the block is idle; the write is
// always taken at once.
module atom_stream_chunk_offset_patcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        atom_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import asco_pkg::*;

	logic [31:0] offset_q;
	logic        room;
	logic        grp_we;
	grp_t        grp;

	// Configuration: a single register, taken on any write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	// Input register, parse state and rewrite; hold the item while the
	// queue lacks room for a full group.
	asco_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.atom_start (atom_start),
		.offset_add (offset_q),
		.room       (room),
		.grp_we     (grp_we),
		.grp        (grp)
	);

	// Result queue: absorb the four-byte bursts, advance one byte a cycle unless stalled.
	asco_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.grp_we      (grp_we),
		.grp         (grp),
		.room        (room),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

// ===== hw/rtl/asco_chk.sv =====
// asco_chk: port-level checks on the chunk-offset patcher, bound to the top.
// Depends on the top level's port list only.
module asco_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        last_of_run
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("stalled result changed");

	// Bytes of a patched entry are queued together: a non-final byte is
	// always followed at once by the next.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("result run broken");

	// Output out of an empty queue comes from an item accepted earlier at the input.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without item");

	// The input stalls only while an accepted item is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(in_valid && !in_stall) || $past(in_stall))
		else $error("stall with no item held");

endmodule

bind atom_stream_chunk_offset_patcher asco_chk u_asco_chk (.*);
